// ----- src/gfd_pkg.sv -----
// shared types and constants for the gamepad frame decoder
`default_nettype none

package gfd_pkg;

  localparam int FRAME_BYTES = 9;
  localparam int POS_W       = 5;
  localparam int SPEED_W     = 11;
  localparam int DB_W        = 10;

  localparam logic [7:0] CMD_START = 8'h01;
  localparam logic [7:0] CMD_POLL  = 8'h42;
  localparam logic [7:0] CMD_IDLE  = 8'hFF;

  localparam logic [7:0] ID_ANALOG  = 8'h73;
  localparam logic [7:0] ID_DIGITAL = 8'h41;
  localparam logic [7:0] ID_ACK     = 8'h5A;

  localparam logic signed [SPEED_W:0] SPEED_OFFSET = 12'sd1023;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_ID   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_ACK  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_R    = POS_W'(5);
  localparam logic [POS_W-1:0] POS_Y    = POS_W'(7);
  localparam logic [POS_W-1:0] POS_X    = POS_W'(8);

  localparam logic [DB_W-1:0] DEADBAND_RESET = DB_W'(100);

  typedef enum logic [1:0] {
    MODE_ANALOG  = 2'd0,
    MODE_DIGITAL = 2'd1,
    MODE_UNKNOWN = 2'd2
  } pad_mode_t;

  typedef logic signed [SPEED_W-1:0] speed_t;

endpackage

`default_nettype wire

// ----- src/gfd_if.sv -----
// channel interfaces for received bytes, decoded results and configuration
`default_nettype none

interface gfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gfd_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        next_tx_byte;
  logic              frame_done;
  logic [1:0]        pad_mode;
  logic              speed_fresh;
  logic signed [10:0] speed_x;
  logic signed [10:0] speed_y;
  logic signed [10:0] speed_r;

  modport source (output valid, output next_tx_byte, output frame_done, output pad_mode,
                  output speed_fresh, output speed_x, output speed_y, output speed_r,
                  input ready);
  modport sink   (input valid, input next_tx_byte, input frame_done, input pad_mode,
                  input speed_fresh, input speed_x, input speed_y, input speed_r,
                  output ready);
endinterface

interface gfd_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] deadband;

  modport source (output valid, output deadband, input ready);
  modport sink   (input valid, input deadband, output ready);
endinterface

`default_nettype wire

// ----- src/gamepad_frame_decoder.sv -----
// gamepad poll frame decoder top level
// One received byte is taken per transaction and yields one result in the following cycle in an output
// register; a new byte is accepted every cycle while the result side keeps up, since ready
// only drops when the output register is full and stalled. Each result carries the command
// byte for the next frame position. At the last byte of a frame the pad mode is reported and,
// for analog frames, the held x, y and r speeds are refreshed with the deadband applied.
// The deadband register may only be written while no transaction is outstanding.
`default_nettype none

module gamepad_frame_decoder (
  input  wire logic   clk,
  input  wire logic   rst_n,
  gfd_in_if.sink      in_ch,
  gfd_out_if.source   out_ch,
  gfd_cfg_if.sink     cfg_ch
);
  import gfd_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       cap_id_r, cap_ack_r, cap_r_r, cap_y_r, cap_x_r;
  logic [7:0]       id_b, ack_b, r_b, y_b, x_b;
  speed_t           held_x_r, held_y_r, held_r_r;
  speed_t           held_x_nxt, held_y_nxt, held_r_nxt;
  logic [DB_W-1:0]  deadband_r;

  logic             out_valid_r;
  logic [7:0]       tx_r, tx_nxt;
  logic             done_r, done_nxt;
  pad_mode_t        mode_r, mode_nxt;
  logic             fresh_r, fresh_nxt;

  logic             in_fire;
  logic             last_pos;

  function automatic speed_t calc_speed(input logic [7:0] b, input logic neg,
                                        input logic [DB_W-1:0] th);
    logic signed [SPEED_W:0] v;
    logic signed [SPEED_W:0] th_s;
    begin
      v    = $signed({1'b0, b, 3'b000}) - SPEED_OFFSET;
      th_s = $signed({2'b00, th});
      if (neg) begin
        v = -v;
      end
      if (v <= th_s && v >= -th_s) begin
        v = '0;
      end
      calc_speed = v[SPEED_W-1:0];
    end
  endfunction

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign last_pos     = (pos_r >= POS_LAST);

  // bytes captured in this transaction are used at once
  assign id_b  = (pos_r == POS_ID)  ? in_ch.rx_byte : cap_id_r;
  assign ack_b = (pos_r == POS_ACK) ? in_ch.rx_byte : cap_ack_r;
  assign r_b   = (pos_r == POS_R)   ? in_ch.rx_byte : cap_r_r;
  assign y_b   = (pos_r == POS_Y)   ? in_ch.rx_byte : cap_y_r;
  assign x_b   = (pos_r == POS_X)   ? in_ch.rx_byte : cap_x_r;

  always_comb begin
    pos_nxt    = last_pos ? '0 : pos_r + POS_W'(1);
    done_nxt   = last_pos;
    mode_nxt   = MODE_ANALOG;
    fresh_nxt  = 1'b0;
    held_x_nxt = held_x_r;
    held_y_nxt = held_y_r;
    held_r_nxt = held_r_r;
    if (last_pos) begin
      priority if (id_b == ID_ANALOG && ack_b == ID_ACK) begin
        fresh_nxt  = 1'b1;
        held_y_nxt = calc_speed(y_b, 1'b0, deadband_r);
        held_x_nxt = calc_speed(x_b, 1'b1, deadband_r);
        held_r_nxt = calc_speed(r_b, 1'b0, deadband_r);
      end else if (id_b == ID_DIGITAL && ack_b == ID_ACK) begin
        mode_nxt = MODE_DIGITAL;
      end else begin
        mode_nxt = MODE_UNKNOWN;
      end
    end
    priority if (pos_nxt == '0) begin
      tx_nxt = CMD_START;
    end else if (pos_nxt == POS_W'(1)) begin
      tx_nxt = CMD_POLL;
    end else begin
      tx_nxt = CMD_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      held_x_r    <= '0;
      held_y_r    <= '0;
      held_r_r    <= '0;
      deadband_r  <= DEADBAND_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        deadband_r <= cfg_ch.deadband;
      end
      if (in_fire) begin
        pos_r       <= pos_nxt;
        held_x_r    <= held_x_nxt;
        held_y_r    <= held_y_nxt;
        held_r_r    <= held_r_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cap_id_r  <= id_b;
      cap_ack_r <= ack_b;
      cap_r_r   <= r_b;
      cap_y_r   <= y_b;
      cap_x_r   <= x_b;
      tx_r      <= tx_nxt;
      done_r    <= done_nxt;
      mode_r    <= mode_nxt;
      fresh_r   <= fresh_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.next_tx_byte = tx_r;
  assign out_ch.frame_done   = done_r;
  assign out_ch.pad_mode     = mode_r;
  assign out_ch.speed_fresh  = fresh_r;
  assign out_ch.speed_x      = held_x_r;
  assign out_ch.speed_y      = held_y_r;
  assign out_ch.speed_r      = held_r_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("frame position out of range");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted byte gave no result");

  a_fresh_analog: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && fresh_r |-> done_r && mode_r == MODE_ANALOG)
    else $error("speed update outside an analog frame end");

  a_done_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> tx_r == CMD_START && pos_r == '0)
    else $error("frame end did not restart the frame");

  a_hold_speeds: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !fresh_nxt |=> $stable(held_x_r) && $stable(held_y_r) && $stable(held_r_r))
    else $error("held speeds changed without an analog frame");

endmodule

`default_nettype wire
